>>> rtl/core/rhw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhw_pkg - receive ring header walker shared definitions
// Types, codes and constants used by the walker front end, queue, back end
// and port checker.
// ----------------------------------------------------------------------------
package rhw_pkg;

    // Ring geometry default
    localparam int unsigned RING_BYTES_DEF = 32768;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BATCH_LIMIT   = 1'b0,
        CFG_ERR_RUN_LIMIT = 1'b1
    } cfg_idx_t;

    localparam logic [7:0] BATCH_LIMIT_RST   = 8'd64;
    localparam logic [3:0] ERR_RUN_LIMIT_RST = 4'd5;

    // Header decode
    localparam logic [15:0] HDR_OK_MASK  = 16'h0001;
    localparam logic [15:0] HDR_ERR_MASK = 16'h003E;
    localparam logic [15:0] LEN_MIN      = 16'd60;
    localparam logic [15:0] LEN_MAX      = 16'd1536;
    localparam logic [10:0] CRC_BYTES    = 11'd4;
    localparam logic [11:0] HDR_ROUND    = 12'd7;   // 4 header bytes + 3 to round up
    localparam logic [15:0] HDR_BYTES    = 16'd4;
    localparam logic [15:0] RPTR_BIAS    = 16'd16;
    localparam logic [3:0]  ERR_RUN_MAX  = 4'd15;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // Result actions
    typedef enum logic [2:0] {
        ACT_DELIVER = 3'd0,
        ACT_SKIP    = 3'd1,
        ACT_RESET   = 3'd2,
        ACT_NONE    = 3'd3,
        ACT_INVALID = 3'd4,
        ACT_FULL    = 3'd5,
        ACT_DISCARD = 3'd6
    } action_t;

    // Classified header, as queued for the back end
    typedef struct packed {
        logic        flush;
        logic        batch_start;
        logic        no_pkt;
        logic        hdr_valid;
        logic        hdr_err;
        logic [11:0] len_adv;
        logic [10:0] data_len;
        logic [15:0] wptr_mod;
    } q_entry_t;

endpackage

>>> rtl/core/rhw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhw_if - receive ring header walker channels
// Header request channel and result request channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rhw_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic        batch_start;
    logic        isr_rok;
    logic [15:0] hdr_status;
    logic [15:0] hdr_length;
    logic [15:0] write_ptr;

    modport source (
        output valid, cmd, batch_start, isr_rok, hdr_status, hdr_length, write_ptr,
        input  ready
    );
    modport sink (
        input  valid, cmd, batch_start, isr_rok, hdr_status, hdr_length, write_ptr,
        output ready
    );
endinterface

interface rhw_out_if;
    import rhw_pkg::*;
    logic        valid;
    logic        ready;
    action_t     action;
    logic [15:0] read_ptr_reg;
    logic [15:0] data_offset;
    logic [10:0] data_length;
    logic [3:0]  error_run_out;
    logic [31:0] error_total;
    logic [31:0] good_total;

    modport source (
        output valid, action, read_ptr_reg, data_offset, data_length,
               error_run_out, error_total, good_total,
        input  ready
    );
    modport sink (
        input  valid, action, read_ptr_reg, data_offset, data_length,
               error_run_out, error_total, good_total,
        output ready
    );
endinterface

>>> rtl/core/rx_ring_header_walker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_ring_header_walker_core - receive ring header walker
// Walks the 4-byte headers of a receive ring: delivers good packets, skips
// and counts error packets, resets the ring on an error run and discards
// packets in flush mode.
//
//   channel   | dir | handshake     | request carries
//   ----------+-----+---------------+------------------------------------------
//   in_ch     | in  | valid/ready   | cmd, batch_start, isr_rok, header, wptr
//   out_ch    | out | valid/ready   | action, read pointer value, data, counts
//   cfg_*     | in  | write enable  | batch_limit (0), error_run_limit (1)
//
// One header a cycle sustained while out_ch does not stall; a result request
// becomes valid once its header has been written into the queue and then
// into the walker register, and it leaves when out_ch.ready is high.
// The walker's pointer update, computed combinationally, sets the rate.
// Reset clears pointer, counters and queue; configuration returns to
// its defaults. Output stall backs up the two-entry queue, then in_ch.ready.
// ----------------------------------------------------------------------------
module rx_ring_header_walker_core #(
    parameter int unsigned RING_BYTES = rhw_pkg::RING_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rhw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rhw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    rhw_in_if.sink                          in_ch,
    rhw_out_if.source                       out_ch
);
    import rhw_pkg::*;

    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_not_empty;
    q_entry_t q_in;
    q_entry_t q_head;

    // Classify headers
    rhw_front #(
        .RING_BYTES (RING_BYTES)
    ) u_front (
        .in_ch   (in_ch),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    // Decouple front and back
    rhw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // Walk the ring
    rhw_back #(
        .RING_BYTES (RING_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_not_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_ch    (out_ch)
    );

endmodule

>>> rtl/core/rhw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhw_front - header classifier
// Accepts header requests and decodes everything that does not depend on
// walker state: validity, error flags, advance length and write pointer
// reduced into the ring.
// ----------------------------------------------------------------------------
module rhw_front #(
    parameter int unsigned RING_BYTES = rhw_pkg::RING_BYTES_DEF
) (
    rhw_in_if.sink            in_ch,
    input  logic              q_full,
    output logic              q_push,
    output rhw_pkg::q_entry_t q_entry
);
    import rhw_pkg::*;

    localparam int unsigned RED_STEPS = 3;   // write pointer holds under 8 rings

    logic [17:0] wred [RED_STEPS+1];
    logic        hdr_ok;
    logic        len_ok;

    // Accept whenever the queue has room
    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;

    // Reduce the write pointer modulo the ring size, one binary digit a step
    always_comb
    begin
        wred[0] = {2'b00, in_ch.write_ptr};
        for (int k = 0; k < RED_STEPS; k++)
        begin
            if (wred[k] >= 18'(RING_BYTES << (RED_STEPS - 1 - k)))
                wred[k+1] = wred[k] - 18'(RING_BYTES << (RED_STEPS - 1 - k));
            else
                wred[k+1] = wred[k];
        end
    end

    // Classify the header
    assign hdr_ok = (in_ch.hdr_status & HDR_OK_MASK) != 16'd0;
    assign len_ok = (in_ch.hdr_length >= LEN_MIN) && (in_ch.hdr_length <= LEN_MAX);

    always_comb
    begin
        q_entry.flush       = in_ch.cmd;
        q_entry.batch_start = in_ch.batch_start;
        q_entry.no_pkt      = in_ch.batch_start && !hdr_ok && !in_ch.isr_rok;
        q_entry.hdr_valid   = hdr_ok && len_ok;
        q_entry.hdr_err     = (in_ch.hdr_status & HDR_ERR_MASK) != 16'd0;
        q_entry.len_adv     = {1'b0, in_ch.hdr_length[10:0]} + HDR_ROUND;
        q_entry.data_len    = in_ch.hdr_length[10:0] - CRC_BYTES;
        q_entry.wptr_mod    = wred[RED_STEPS][15:0];
    end

endmodule

>>> rtl/core/rhw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhw_queue - classified header queue
// Short first-in first-out store that lets the classifier and the walker
// stall independently.
// ----------------------------------------------------------------------------
module rhw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rhw_pkg::q_entry_t push_entry,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output rhw_pkg::q_entry_t head
);
    import rhw_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> rtl/core/rhw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhw_back - ring walker
// Holds the read pointer, batch and error state, applies one classified
// header a cycle while the result request is not stalled, and registers the result request.
// ----------------------------------------------------------------------------
module rhw_back #(
    parameter int unsigned RING_BYTES = rhw_pkg::RING_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rhw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rhw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            q_valid,
    input  rhw_pkg::q_entry_t               q_head,
    output logic                            q_pop,
    rhw_out_if.source                       out_ch
);
    import rhw_pkg::*;

    localparam int unsigned PTR_W = $clog2(RING_BYTES);
    localparam logic [PTR_W:0] RING_SIZE = (PTR_W + 1)'(RING_BYTES);

    // Configuration
    logic [7:0]       batch_limit_reg;
    logic [3:0]       err_limit_reg;

    // Walker state
    logic [PTR_W-1:0] ptr_reg,   ptr_next;
    logic [3:0]       run_reg,   run_next;
    logic [7:0]       bc_reg,    bc_next;
    logic [31:0]      errc_reg,  errc_next;
    logic [31:0]      goodc_reg, goodc_next;

    // Result request
    logic             ovalid_reg;
    action_t          act_reg,   act_next;
    logic [15:0]      off_reg,   off_next;
    logic [10:0]      len_reg,   len_next;

    logic             take;
    logic [PTR_W:0]   sum;
    logic [PTR_W:0]   sum_rnd;
    logic [PTR_W-1:0] ptr_adv;
    logic [7:0]       bc_eff;
    logic [3:0]       run_inc;

    assign take  = q_valid && (!ovalid_reg || out_ch.ready);
    assign q_pop = take;

    // Next read pointer: round length plus header up to a dword, wrap in ring
    assign sum     = {1'b0, ptr_reg} + (PTR_W + 1)'(q_head.len_adv);
    assign sum_rnd = {sum[PTR_W:2], 2'b00};
    always_comb
    begin
        if (sum_rnd >= RING_SIZE)
            ptr_adv = PTR_W'(sum_rnd - RING_SIZE);
        else
            ptr_adv = sum_rnd[PTR_W-1:0];
    end

    assign bc_eff  = q_head.batch_start ? 8'd0 : bc_reg;
    assign run_inc = (run_reg != ERR_RUN_MAX) ? run_reg + 4'd1 : run_reg;

    // Decide the action and state update for the head entry
    always_comb
    begin
        ptr_next   = ptr_reg;
        run_next   = run_reg;
        bc_next    = bc_reg;
        errc_next  = errc_reg;
        goodc_next = goodc_reg;
        act_next   = ACT_NONE;
        off_next   = 16'd0;
        len_next   = 11'd0;
        if (q_head.flush)
        begin
            if (q_head.wptr_mod == 16'(ptr_reg))
                act_next = ACT_NONE;
            else if (!q_head.hdr_valid)
                act_next = ACT_INVALID;
            else
            begin
                ptr_next = ptr_adv;
                act_next = ACT_DISCARD;
            end
        end
        else
        begin
            bc_next = bc_eff;
            if (q_head.no_pkt)
                act_next = ACT_NONE;
            else if (bc_eff >= batch_limit_reg)
                act_next = ACT_FULL;
            else if (!q_head.hdr_valid)
                act_next = ACT_INVALID;
            else if (q_head.hdr_err)
            begin
                errc_next = errc_reg + 32'd1;
                if (run_inc >= err_limit_reg)
                begin
                    ptr_next = '0;
                    run_next = 4'd0;
                    act_next = ACT_RESET;
                end
                else
                begin
                    ptr_next = ptr_adv;
                    run_next = run_inc;
                    act_next = ACT_SKIP;
                end
            end
            else
            begin
                run_next   = 4'd0;
                off_next   = 16'(ptr_reg) + HDR_BYTES;
                len_next   = q_head.data_len;
                ptr_next   = ptr_adv;
                goodc_next = goodc_reg + 32'd1;
                bc_next    = bc_eff + 8'd1;
                act_next   = ACT_DELIVER;
            end
        end
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_limit_reg <= BATCH_LIMIT_RST;
            err_limit_reg   <= ERR_RUN_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BATCH_LIMIT:   batch_limit_reg <= cfg_wdata[7:0];
                CFG_ERR_RUN_LIMIT: err_limit_reg   <= cfg_wdata[3:0];
                default:           ;
            endcase
        end
    end

    // Advance walker state and the result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            run_reg    <= 4'd0;
            bc_reg     <= 8'd0;
            errc_reg   <= 32'd0;
            goodc_reg  <= 32'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                ptr_reg   <= ptr_next;
                run_reg   <= run_next;
                bc_reg    <= bc_next;
                errc_reg  <= errc_next;
                goodc_reg <= goodc_next;
            end
            if (take)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Hold result payload until taken
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            act_reg <= act_next;
            off_reg <= off_next;
            len_reg <= len_next;
        end
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.action        = act_reg;
    assign out_ch.read_ptr_reg  = 16'(ptr_reg) - RPTR_BIAS;
    assign out_ch.data_offset   = off_reg;
    assign out_ch.data_length   = len_reg;
    assign out_ch.error_run_out = run_reg;
    assign out_ch.error_total   = errc_reg;
    assign out_ch.good_total    = goodc_reg;

endmodule

>>> rtl/core/rhw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhw_checker - receive ring header walker port checks
// Watches the result channel of the top level and checks action coherence.
// ----------------------------------------------------------------------------
module rhw_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 valid,
    input logic                 ready,
    input rhw_pkg::action_t     action,
    input logic [15:0]          hw_rptr,
    input logic [15:0]          data_offset,
    input logic [10:0]          data_length,
    input logic [3:0]           error_run
);
    import rhw_pkg::*;

    // Hold a stalled result request
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(action) && $stable(data_offset))
        else $error("result request changed while stalled");

    // Drop data fields on anything but a delivery
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && action != ACT_DELIVER |-> data_offset == 16'd0 && data_length == 11'd0)
        else $error("data fields set on a non-delivery result");

    // Ring reset puts the pointer at the start and clears the error run
    a_ring_reset: assert property (@(posedge clk) disable iff (!rst_n)
        valid && action == ACT_RESET |-> hw_rptr == 16'hFFF0 && error_run == 4'd0)
        else $error("ring reset left pointer or error run set");

    // Delivery clears the error run and gives dword aligned data of at least 56 bytes
    a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        valid && action == ACT_DELIVER |-> error_run == 4'd0 && data_offset[1:0] == 2'd0
                                           && data_length >= 11'd56)
        else $error("delivery with error run or bad data fields");

endmodule

bind rx_ring_header_walker_core rhw_checker u_rhw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (out_ch.valid),
    .ready       (out_ch.ready),
    .action      (out_ch.action),
    .hw_rptr     (out_ch.read_ptr_reg),
    .data_offset (out_ch.data_offset),
    .data_length (out_ch.data_length),
    .error_run   (out_ch.error_run_out)
);
